FILE: hdl/glyph_slot_cache_lookup_top_assert.svh
// Assertion macros for the glyph slot cache lookup checker.
// Depends on nothing; included by the checker file.
`ifndef GLYPH_SLOT_CACHE_LOOKUP_TOP_ASSERT_SVH
`define GLYPH_SLOT_CACHE_LOOKUP_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define GSCL_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also applies during reset.
`define GSCL_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/gscl_pkg.sv
// Shared types and constants for the glyph slot cache lookup block.
// Used by the scan unit, the top level and the checkers; depends on nothing.
`default_nettype none

package gscl_pkg;

  localparam int SLOTS_DEF    = 256;
  localparam int PERM_BIT_DEF = 7;

  localparam int CODE_W     = 16;
  localparam int CNT_W      = 16;
  localparam int ATTR_W     = 8;
  localparam int SLOT_IDX_W = 8;
  localparam int FREQ_SHIFT = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // One slot of the cache as it sits in the RAM.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  count;
    logic [ATTR_W-1:0] attr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic start;
    logic eval;
  } scan_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/glyph_slot_cache_lookup_top.sv
// Glyph slot cache lookup: a hit ends the scan at the matching slot, a miss scans all SLOTS
// slots, one slot per cycle through the registered RAM read port. The next request can be
// taken in the same cycle that the result is offered. A result still held in the output
// register stalls the next one. Reset is synchronous, active low; a clearing pass then
// zeroes the store, and no request is accepted during it. Depends on gscl_pkg, gscl_ram
// and gscl_scan.
`default_nettype none

module glyph_slot_cache_lookup_top #(
  parameter int SLOTS    = gscl_pkg::SLOTS_DEF,
  parameter int PERM_BIT = gscl_pkg::PERM_BIT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [gscl_pkg::CODE_W-1:0]     in_tdata,    // [15:0] char_code
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [gscl_pkg::SLOT_IDX_W-1:0]      out_tdata,   // [7:0] slot_index
  output logic [1:0]                           out_tuser,   // [0] hit, [1] evicted
  input  wire logic                            cfg_wr_en,
  input  wire logic [gscl_pkg::ATTR_W-1:0]     cfg_wr_data  // current_attribute
);
  import gscl_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = AW + 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]            state_r,     state_nxt;
  logic [CW-1:0]         cnt_r,       cnt_nxt;
  logic                  ev_vld_r,    ev_vld_nxt;
  logic [AW-1:0]         ev_idx_r,    ev_idx_nxt;
  logic                  out_vld_r,   out_vld_nxt;
  logic [ATTR_W-1:0]     attr_r,      attr_nxt;
  logic [CODE_W-1:0]     code_r,      code_nxt;
  logic                  hit_r,       hit_nxt;
  logic [AW-1:0]         hit_slot_r,  hit_slot_nxt;
  entry_t                hit_ent_r,   hit_ent_nxt;
  logic [AW-1:0]         res_slot_r,  res_slot_nxt;
  logic                  res_hit_r,   res_hit_nxt;
  logic                  res_evict_r, res_evict_nxt;
  logic [SLOT_IDX_W-1:0] out_data_r,  out_data_nxt;
  logic [1:0]            out_user_r,  out_user_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  scan_ctl_t     scan_ctl;
  logic          hit_now;
  logic          free_ok;
  logic [AW-1:0] free_slot;
  logic          victim_ok;
  logic [AW-1:0] victim_slot;
  logic [AW-1:0] miss_slot;

  gscl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gscl_scan #(
    .SLOTS    (SLOTS),
    .PERM_BIT (PERM_BIT)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .idx         (ev_idx_r),
    .ent         (ram_rdata),
    .code        (code_r),
    .attr        (attr_r),
    .hit_now     (hit_now),
    .free_ok     (free_ok),
    .free_slot   (free_slot),
    .victim_ok   (victim_ok),
    .victim_slot (victim_slot)
  );

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    if (free_ok) begin
      miss_slot = free_slot;
    end else if (victim_ok) begin
      miss_slot = victim_slot;
    end else begin
      miss_slot = AW'(SLOTS - 1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    out_vld_nxt   = out_vld_r;
    attr_nxt      = attr_r;
    code_nxt      = code_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    hit_ent_nxt   = hit_ent_r;
    res_slot_nxt  = res_slot_r;
    res_hit_nxt   = res_hit_r;
    res_evict_nxt = res_evict_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    scan_ctl      = '0;

    if (cfg_wr_en) begin
      attr_nxt = cfg_wr_data;
    end
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(SLOTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          code_nxt       = in_tdata;
          cnt_nxt        = '0;
          hit_nxt        = 1'b0;
          scan_ctl.start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Each read is issued in the cycle before its compare on the registered data.
        if (cnt_r < CW'(SLOTS)) begin
          ram_raddr  = cnt_r[AW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = cnt_r[AW-1:0];
        end
        if (ev_vld_r) begin
          scan_ctl.eval = 1'b1;
          if (hit_now) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = ev_idx_r;
            hit_ent_nxt  = ram_rdata;
            ev_vld_nxt   = 1'b0;
            state_nxt    = ST_WRITE;
          end else if (ev_idx_r == AW'(SLOTS - 1)) begin
            ev_vld_nxt = 1'b0;
            state_nxt  = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        if (hit_r) begin
          ram_waddr = hit_slot_r;
          ram_wdata = hit_ent_r;
          if (hit_ent_r.count != COUNT_MAX) begin
            ram_wdata.count = hit_ent_r.count + CNT_W'(1);
          end
          res_slot_nxt  = hit_slot_r;
          res_hit_nxt   = 1'b1;
          res_evict_nxt = 1'b0;
        end else begin
          ram_waddr       = miss_slot;
          ram_wdata.code  = code_r;
          ram_wdata.count = CNT_W'(1);
          ram_wdata.attr  = attr_r;
          res_slot_nxt    = miss_slot;
          res_hit_nxt     = 1'b0;
          // Without a free slot every slot holds a nonzero code.
          res_evict_nxt   = !free_ok;
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = SLOT_IDX_W'(res_slot_r);
          out_user_nxt = {res_evict_r, res_hit_r};
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      ev_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      attr_r    <= '0;
      hit_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      ev_vld_r  <= ev_vld_nxt;
      out_vld_r <= out_vld_nxt;
      attr_r    <= attr_nxt;
      hit_r     <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    code_r      <= code_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_ent_r   <= hit_ent_nxt;
    res_slot_r  <= res_slot_nxt;
    res_hit_r   <= res_hit_nxt;
    res_evict_r <= res_evict_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

FILE: hdl/gscl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the slot store of the cache.
`default_nettype none

module gscl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/gscl_scan.sv
// Compare unit: checks one slot per cycle for a hit and tracks the
// lowest free slot and the eviction candidate. Depends on gscl_pkg.
`default_nettype none

module gscl_scan #(
  parameter int SLOTS    = gscl_pkg::SLOTS_DEF,
  parameter int PERM_BIT = gscl_pkg::PERM_BIT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gscl_pkg::scan_ctl_t           ctl,
  input  wire logic [$clog2(SLOTS)-1:0]      idx,
  input  wire gscl_pkg::entry_t              ent,
  input  wire logic [gscl_pkg::CODE_W-1:0]   code,
  input  wire logic [gscl_pkg::ATTR_W-1:0]   attr,
  output logic                               hit_now,
  output logic                               free_ok,
  output logic [$clog2(SLOTS)-1:0]           free_slot,
  output logic                               victim_ok,
  output logic [$clog2(SLOTS)-1:0]           victim_slot
);
  import gscl_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam logic [ATTR_W-1:0] KEEP = ~(ATTR_W'(1) << PERM_BIT);

  logic              match;
  logic              elig;
  logic              free_ok_r,  free_ok_nxt;
  logic              vic_ok_r,   vic_ok_nxt;
  logic [AW-1:0]     free_slot_r, free_slot_nxt;
  logic [AW-1:0]     vic_slot_r,  vic_slot_nxt;
  logic [CNT_W-1:0]  vic_cnt_r,   vic_cnt_nxt;

  // The permanent bit is ignored on both sides of the attribute compare.
  assign match   = (ent.code == code) && ((ent.attr & KEEP) == (attr & KEEP));
  assign elig    = ent.attr[PERM_BIT] && ((ent.count >> FREQ_SHIFT) != '0);
  assign hit_now = ctl.eval && match;

  always_comb begin
    free_ok_nxt   = free_ok_r;
    free_slot_nxt = free_slot_r;
    vic_ok_nxt    = vic_ok_r;
    vic_slot_nxt  = vic_slot_r;
    vic_cnt_nxt   = vic_cnt_r;
    if (ctl.start) begin
      free_ok_nxt = 1'b0;
      vic_ok_nxt  = 1'b0;
    end else if (ctl.eval && !match) begin
      if ((ent.code == '0) && !free_ok_r) begin
        free_ok_nxt   = 1'b1;
        free_slot_nxt = idx;
      end
      // Strict less-than keeps the lowest index among equal counts.
      if (elig && (!vic_ok_r || (ent.count < vic_cnt_r))) begin
        vic_ok_nxt   = 1'b1;
        vic_slot_nxt = idx;
        vic_cnt_nxt  = ent.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_ok_r <= 1'b0;
      vic_ok_r  <= 1'b0;
    end else begin
      free_ok_r <= free_ok_nxt;
      vic_ok_r  <= vic_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_slot_r <= free_slot_nxt;
    vic_slot_r  <= vic_slot_nxt;
    vic_cnt_r   <= vic_cnt_nxt;
  end

  assign free_ok     = free_ok_r;
  assign free_slot   = free_slot_r;
  assign victim_ok   = vic_ok_r;
  assign victim_slot = vic_slot_r;

endmodule

`default_nettype wire

FILE: hdl/gscl_checker.sv
// Port-level checker for the glyph slot cache lookup top level, with its bind.
// Depends on gscl_pkg and the assertion macro header.
`default_nettype none
`include "glyph_slot_cache_lookup_top_assert.svh"

module gscl_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [gscl_pkg::SLOT_IDX_W-1:0] out_tdata,
  input wire logic [1:0]                      out_tuser
);
  import gscl_pkg::*;

  logic out_stall;
  logic in_acc;

  assign out_stall = out_tvalid && !out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // A stalled result transaction stays offered with its slot index unchanged.
  `GSCL_ASSERT_RUN(a_out_hold, clk, rst_n, out_stall |=> out_tvalid, "result dropped")
  `GSCL_ASSERT_RUN(a_out_stable, clk, rst_n, out_stall |=> $stable(out_tdata), "result changed")

  // The block works on one request at a time.
  `GSCL_ASSERT_RUN(a_busy_after_accept, clk, rst_n, in_acc |=> !in_tready, "accepted while busy")

  // A hit never replaces a slot.
  `GSCL_ASSERT_RUN(a_hit_no_evict, clk, rst_n, out_tvalid |-> !(&out_tuser), "hit with eviction")

  // Reset leaves no result pending and no request accepted.
  `GSCL_ASSERT_ANY(a_reset_idle, clk, !rst_n |=> !out_tvalid && !in_tready, "busy after reset")

endmodule

bind glyph_slot_cache_lookup_top gscl_checker u_gscl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: bench/glyph_cache_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the glyph slot cache lookup: keeps its own copy of the slot store,
// predicts every lookup transaction and compares the result stream in order.
// Depends on gscl_pkg for the field widths and the count limits.

module glyph_cache_checker #(
  parameter int SLOTS    = gscl_pkg::SLOTS_DEF,
  parameter int PERM_BIT = gscl_pkg::PERM_BIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [gscl_pkg::CODE_W-1:0]       in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [gscl_pkg::SLOT_IDX_W-1:0]   out_tdata,
  input  logic [1:0]                        out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [gscl_pkg::ATTR_W-1:0]       cfg_wr_data,
  output int                                fail_count,
  output int                                pending
);

  typedef struct packed {
    logic [gscl_pkg::SLOT_IDX_W-1:0] slot;
    logic                            hit;
    logic                            evicted;
  } lookup_result_t;

  logic [gscl_pkg::CODE_W-1:0] slot_code  [SLOTS];
  logic [gscl_pkg::CNT_W-1:0]  slot_count [SLOTS];
  logic [gscl_pkg::ATTR_W-1:0] slot_attr  [SLOTS];
  logic [gscl_pkg::ATTR_W-1:0] cur_attr;
  lookup_result_t              lookup_q[$];
  int                          mismatches = 0;
  int                          outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  // Finds or places one code and updates the mirrored store the way the block does.
  function automatic lookup_result_t place_glyph(input logic [gscl_pkg::CODE_W-1:0] code);
    logic [gscl_pkg::ATTR_W-1:0] perm, keep, want;
    logic [gscl_pkg::CNT_W-1:0]  victim_cnt;
    logic                        found, have_free, have_victim;
    int                          k, slot, free_slot, victim;
    lookup_result_t              res;
    perm        = 8'd1 << PERM_BIT;
    keep        = ~perm;
    want        = cur_attr & keep;
    victim_cnt  = '0;
    found       = 1'b0;
    have_free   = 1'b0;
    have_victim = 1'b0;
    slot        = 0;
    free_slot   = 0;
    victim      = 0;
    for (k = 0; k < SLOTS; k++) begin
      if (!found) begin
        if (slot_code[k] == code && (slot_attr[k] & keep) == want) begin
          found = 1'b1;
          slot  = k;
        end else begin
          if (slot_code[k] == '0 && !have_free) begin
            have_free = 1'b1;
            free_slot = k;
          end
          // Only permanent slots that have been used often enough may be chosen as the victim.
          if ((slot_attr[k] & perm) != '0 && (slot_count[k] >> gscl_pkg::FREQ_SHIFT) != '0 &&
              (!have_victim || slot_count[k] < victim_cnt)) begin
            have_victim = 1'b1;
            victim      = k;
            victim_cnt  = slot_count[k];
          end
        end
      end
    end
    res.hit     = found;
    res.evicted = 1'b0;
    if (found) begin
      if (slot_count[slot] != gscl_pkg::COUNT_MAX) slot_count[slot] = slot_count[slot] + 1'b1;
    end else begin
      if (have_free) slot = free_slot;
      else if (have_victim) slot = victim;
      else slot = SLOTS - 1;
      res.evicted      = (slot_code[slot] != '0);
      slot_code[slot]  = code;
      slot_attr[slot]  = cur_attr;
      slot_count[slot] = gscl_pkg::CNT_W'(1);
    end
    res.slot = slot[gscl_pkg::SLOT_IDX_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string field, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want_res;
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_code[k]  = '0;
        slot_count[k] = '0;
        slot_attr[k]  = '0;
      end
      cur_attr = '0;
      lookup_q.delete();
    end else begin
      if (cfg_wr_en) cur_attr = cfg_wr_data;
      if (in_tvalid && in_tready) lookup_q.push_back(place_glyph(in_tdata));
      if (out_tvalid && out_tready) begin
        if (lookup_q.size() == 0) begin
          $display("%0t: result transaction with no lookup outstanding, expected none, actual slot %0d hit %0b evicted %0b",
                   $time, out_tdata, out_tuser[0], out_tuser[1]);
          mismatches++;
        end else begin
          want_res = lookup_q.pop_front();
          check_field("slot_index", want_res.slot, out_tdata);
          check_field("hit", want_res.hit, out_tuser[0]);
          check_field("evicted", want_res.evicted, out_tuser[1]);
        end
      end
    end
    // Updated late so that the stimulus side reads a settled value at the clock edge.
    outstanding <= lookup_q.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Top of the glyph slot cache bench: clock, reset, lookup and result traffic,
// attribute writes and the verdict. Depends on gscl_pkg, the block and glyph_cache_checker.

module tb;

  localparam int RANDOM_ITEMS   = 1500;
  localparam int SATURATE_ITEMS = 40;
  localparam int LONG_HOLD      = 1500;
  localparam int SETTLE         = gscl_pkg::SLOTS_DEF + 40;
  localparam logic [7:0] PERM   = 8'd1 << gscl_pkg::PERM_BIT_DEF;

  typedef enum int { EP_FRESH, EP_HOT, EP_MIX } episode_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [gscl_pkg::CODE_W-1:0]       in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [gscl_pkg::SLOT_IDX_W-1:0]   out_tdata;
  logic [1:0]                        out_tuser;
  logic                              cfg_wr_en = 1'b0;
  logic [gscl_pkg::ATTR_W-1:0]       cfg_wr_data = '0;
  int                                fail_count;
  int                                pending;

  logic        calm = 1'b1;
  logic        long_hold_req = 1'b0;
  logic [15:0] recent_q[$];
  logic [7:0]  attr_palette[2];
  int          requests_sent = 0;

  glyph_slot_cache_lookup_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  glyph_cache_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] fresh_code();
    case ($urandom_range(0, 19))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] recent_code();
    if (recent_q.size() == 0) return fresh_code();
    return recent_q[$urandom_range(0, recent_q.size() - 1)];
  endfunction

  // A small palette keeps attributes recurring, so earlier entries can hit again.
  function automatic logic [7:0] pick_attr();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return PERM;
      3: return ~PERM;
      4, 5: return attr_palette[$urandom_range(0, 1)];
      6, 7: return attr_palette[$urandom_range(0, 1)] ^ PERM;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_request(input logic [15:0] code);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    recent_q.push_back(code);
    if (recent_q.size() > 48) void'(recent_q.pop_front());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [7:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        gap = idle_gap();
        if (gap == 0) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    episode_t    kind;
    logic [15:0] hot[4];
    int          reps[4];
    int          n, peak, base;
    logic        tie;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // The store is cleared after reset; requests are refused until that is done.
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    attr_palette[0] = 8'($urandom_range(0, 255));
    attr_palette[1] = 8'($urandom_range(0, 255));

    // Every free slot reads as code zero with attribute zero, so this keeps hitting
    // slot zero and builds up its count.
    calm = 1'b1;
    set_attribute(8'h00);
    repeat (SATURATE_ITEMS) send_request(16'h0000);

    // A zero code under another attribute misses and fills a slot that still reads free.
    set_attribute(8'h05);
    send_request(16'h0000);
    send_request(16'h0000);
    send_request(16'hFFFF);
    send_request(16'h0001);
    send_request(16'h8000);
    send_request(16'h7FFF);
    send_request(16'hFFFF);
    send_request(16'h0001);
    // The permanent bit is ignored when matching.
    set_attribute(8'h85);
    send_request(16'hFFFF);
    send_request(16'h1234);
    set_attribute(8'hFF);
    send_request(16'hFFFF);
    send_request(16'h5555);
    send_request(16'hAAAA);
    set_attribute(8'h7F);
    send_request(16'hFFFF);
    set_attribute(PERM);
    send_request(16'h0000);
    send_request(16'h1234);

    // Hold the result side off so the block backs up and refuses requests.
    calm = 1'b0;
    drain();
    base = requests_sent;
    long_hold_req = 1'b1;
    repeat (12) send_request(recent_code());
    drain();

    while (requests_sent - base < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) set_attribute(pick_attr());
      kind = episode_t'($urandom_range(0, 2));
      case (kind)
        EP_FRESH: begin
          n = $urandom_range(8, 32);
          repeat (n) send_request(fresh_code());
        end
        EP_HOT: begin
          // Repeated codes build counts around the eviction threshold; equal counts
          // exercise the lowest-index tie break among permanent slots.
          n    = $urandom_range(1, 4);
          tie  = $urandom_range(0, 1);
          peak = $urandom_range(30, 40);
          for (int i = 0; i < n; i++) begin
            hot[i]  = recent_code();
            reps[i] = tie ? peak : $urandom_range(28, 40);
          end
          for (int r = 0; r < 40; r++) begin
            for (int i = 0; i < n; i++) begin
              if (r < reps[i]) send_request(hot[i]);
            end
          end
        end
        default: begin
          n = $urandom_range(16, 40);
          repeat (n) begin
            if ($urandom_range(0, 9) < 6) send_request(recent_code());
            else send_request(fresh_code());
          end
        end
      endcase
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
